[hdl/mst_pkg.sv]
// Package with shared types, constants and table builders for the spatial tremolo.
package mst_pkg;

    // Fixed frame shape.
    localparam int CHANNELS     = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int TABLE_SIZE_D = 1024;
    localparam int MAX_SETS_D   = 8;

    // Fixed-point layout.
    localparam int PH_FRAC  = 22;
    localparam int LOG_FRAC = 20;
    localparam int ENV_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SET_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SET_MASKS  = 3'd4;

    // Datapath operation codes.
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_ROM   = 4'd2;
    localparam logic [3:0] OP_ENV_A = 4'd3;
    localparam logic [3:0] OP_ENV_B = 4'd4;
    localparam logic [3:0] OP_LIN   = 4'd5;
    localparam logic [3:0] OP_NORM  = 4'd6;
    localparam logic [3:0] OP_SQR   = 4'd7;
    localparam logic [3:0] OP_YMUL  = 4'd8;
    localparam logic [3:0] OP_POW   = 4'd9;
    localparam logic [3:0] OP_VAL   = 4'd10;
    localparam logic [3:0] OP_GC0   = 4'd11;
    localparam logic [3:0] OP_GC1   = 4'd12;
    localparam logic [3:0] OP_CHAN  = 4'd13;
    localparam logic [3:0] OP_WRITE = 4'd14;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
        logic signed [SAMPLE_BITS-1:0] sample_4;
        logic signed [SAMPLE_BITS-1:0] sample_5;
        logic signed [SAMPLE_BITS-1:0] sample_6;
        logic signed [SAMPLE_BITS-1:0] sample_7;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_0;
        logic signed [SAMPLE_BITS-1:0] out_1;
        logic signed [SAMPLE_BITS-1:0] out_2;
        logic signed [SAMPLE_BITS-1:0] out_3;
        logic signed [SAMPLE_BITS-1:0] out_4;
        logic signed [SAMPLE_BITS-1:0] out_5;
        logic signed [SAMPLE_BITS-1:0] out_6;
        logic signed [SAMPLE_BITS-1:0] out_7;
    } out_item_t;

    typedef struct packed {
        logic [30:0] phase_step;
        logic [16:0] depth;
        logic [15:0] gain;
        logic [3:0]  set_count;
        logic [63:0] set_masks;
    } cfg_t;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic deep;
        logic out_busy;
    } sts_t;

    // Integer square root, bit by bit.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > n) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q30 sine from a Taylor series.
    function automatic logic [63:0] sin_q30(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        t2 = (t * t) >> 30;
        term = t;
        sum = t;
        for (int k = 1; k <= 7; k++) begin
            term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) sum = (term > sum) ? 64'd0 : sum - term;
            else sum = sum + term;
        end
        return (sum > (64'd1 << 30)) ? (64'd1 << 30) : sum;
    endfunction

    // Raised-cosine table entry in Q16; the table size is a power of two.
    function automatic logic [ENV_W-1:0] rom_entry(input int i, input int tsize,
                                                   input int tlog);
        int j;
        logic [63:0] s;
        logic [63:0] e;
        j = (i <= tsize - i) ? i : tsize - i;
        s = sin_q30((64'd3373259426 * 64'(j)) >> tlog);
        e = (((s * s) >> 30) + (64'd1 << 13)) >> 14;
        return (e > 64'd65536) ? 17'd65536 : e[ENV_W-1:0];
    endfunction

    // Q30 value of 2^(-2^-k), by repeated square roots of one half.
    function automatic logic [29:0] root_entry(input int k);
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int j = 1; j <= LOG_FRAC; j++) begin
            if (j <= k) r = isqrt64(r << 30);
        end
        return r[29:0];
    endfunction

endpackage

[hdl/multichannel_spatial_tremolo.sv]
// Top level of the multichannel spatial tremolo: configuration registers and core.
//
// One frame of eight signed samples is taken per transfer and one processed frame
// is returned. While the depth is at most 1.0 the envelope is scaled linearly;
// above that it is raised to the depth power by 20 squaring steps and 20
// root-multiply steps. The eight channels are then scaled one per cycle. The
// finished frame sits in an output register, so the next frame may be taken
// while it waits. Configuration writes are always ready and should only be
// issued while no frame is in flight.
module multichannel_spatial_tremolo
    import mst_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_D,
    parameter int MAX_SETS   = MAX_SETS_D
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.phase_step <= 31'd4194304;
            cfg_reg.depth      <= 17'd4096;
            cfg_reg.gain       <= 16'd32768;
            cfg_reg.set_count  <= 4'd2;
            cfg_reg.set_masks  <= 64'd513;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PHASE_STEP: cfg_reg.phase_step <= cfg_data[30:0];
                REG_DEPTH:      cfg_reg.depth      <= cfg_data[16:0];
                REG_GAIN:       cfg_reg.gain       <= cfg_data[15:0];
                REG_SET_COUNT:  cfg_reg.set_count  <= cfg_data[3:0];
                REG_SET_MASKS:  cfg_reg.set_masks  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mst_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_SETS   (MAX_SETS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .in_data   (in_data),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[hdl/mst_ctrl.sv]
// Sequencer that steps the tremolo datapath through one frame.
module mst_ctrl
    import mst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROM   = 4'd1;
    localparam logic [3:0] S_ENV_A = 4'd2;
    localparam logic [3:0] S_ENV_B = 4'd3;
    localparam logic [3:0] S_LIN   = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_SQR   = 4'd6;
    localparam logic [3:0] S_YMUL  = 4'd7;
    localparam logic [3:0] S_POW   = 4'd8;
    localparam logic [3:0] S_VAL   = 4'd9;
    localparam logic [3:0] S_GC0   = 4'd10;
    localparam logic [3:0] S_GC1   = 4'd11;
    localparam logic [3:0] S_CHAN  = 4'd12;
    localparam logic [3:0] S_WRITE = 4'd13;

    localparam logic [4:0] LAST_ITER = 5'(LOG_FRAC - 1);
    localparam logic [4:0] LAST_CHAN = 5'(CHANNELS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ROM;
                end
            end
            S_ROM:
            begin
                cmd.op     = OP_ROM;
                state_next = S_ENV_A;
            end
            S_ENV_A:
            begin
                cmd.op     = OP_ENV_A;
                state_next = S_ENV_B;
            end
            S_ENV_B:
            begin
                cmd.op     = OP_ENV_B;
                state_next = sts.deep ? S_NORM : S_LIN;
            end
            S_LIN:
            begin
                cmd.op     = OP_LIN;
                state_next = S_GC0;
            end
            S_NORM:
            begin
                cmd.op     = OP_NORM;
                step_next  = '0;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.op    = OP_SQR;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_ITER) begin
                    step_next  = '0;
                    state_next = S_YMUL;
                end
            end
            S_YMUL:
            begin
                cmd.op     = OP_YMUL;
                step_next  = '0;
                state_next = S_POW;
            end
            S_POW:
            begin
                cmd.op    = OP_POW;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_ITER) begin
                    step_next  = '0;
                    state_next = S_VAL;
                end
            end
            S_VAL:
            begin
                cmd.op     = OP_VAL;
                state_next = S_GC0;
            end
            S_GC0:
            begin
                cmd.op     = OP_GC0;
                state_next = S_GC1;
            end
            S_GC1:
            begin
                cmd.op     = OP_GC1;
                step_next  = '0;
                state_next = S_CHAN;
            end
            S_CHAN:
            begin
                cmd.op    = OP_CHAN;
                step_next = step_reg + 5'd1;
                if (step_reg == LAST_CHAN) begin
                    step_next  = '0;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (!sts.out_busy) begin
                    cmd.op     = OP_WRITE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

[hdl/mst_dp.sv]
// Datapath: LFO phase, envelope chain, channel scaling and output register.
module mst_dp
    import mst_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_D,
    parameter int MAX_SETS   = MAX_SETS_D
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      cmd,
    input  in_item_t  in_data,
    output sts_t      sts,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int TLOG = $clog2(TABLE_SIZE);
    localparam int PH_W = TLOG + PH_FRAC;
    localparam int SUM_W = PH_W + 2;
    localparam logic [3:0] SETS_MAX = 4'(MAX_SETS);

    // Constant tables.
    logic [ENV_W-1:0] rom_w [TABLE_SIZE+1];
    logic [29:0]      root_w [LOG_FRAC+1];

    for (genvar gi = 0; gi <= TABLE_SIZE; gi++) begin : g_rom
        assign rom_w[gi] = rom_entry(gi, TABLE_SIZE, TLOG);
    end
    for (genvar gk = 0; gk <= LOG_FRAC; gk++) begin : g_root
        assign root_w[gk] = root_entry(gk);
    end

    // Registers.
    logic [PH_W-1:0] phase_reg, snap_reg;
    logic            wrap_reg;
    logic [2:0]      aset_reg;
    logic signed [SAMPLE_BITS-1:0] samp_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] res_reg [CHANNELS];
    logic [ENV_W-1:0] lo_reg, hi_reg, env_reg, val_reg;
    logic [40:0]     acc_reg;
    logic [4:0]      p_reg;
    logic [30:0]     x_reg, m_reg;
    logic [19:0]     frac_reg;
    logic [29:0]     y_reg;
    logic [12:0]     base_reg;
    logic [33:0]     gc0_reg, gc1_reg;
    logic            out_valid_reg;
    out_item_t       out_reg;

    // Saturated settings.
    logic [16:0] d_sat;
    logic [15:0] g_sat;
    logic [3:0]  cnt;
    assign d_sat = (cfg.depth > 17'd65536) ? 17'd65536 : cfg.depth;
    assign g_sat = (cfg.gain > 16'd32768) ? 16'd32768 : cfg.gain;
    assign cnt   = (cfg.set_count == 4'd0) ? 4'd1 :
                   ((cfg.set_count > SETS_MAX) ? SETS_MAX : cfg.set_count);

    assign sts.deep     = (d_sat > 17'd4096);
    assign sts.out_busy = out_valid_reg && out_stall;

    // Input unpacking.
    logic signed [SAMPLE_BITS-1:0] in_w [CHANNELS];
    assign in_w[0] = in_data.sample_0;
    assign in_w[1] = in_data.sample_1;
    assign in_w[2] = in_data.sample_2;
    assign in_w[3] = in_data.sample_3;
    assign in_w[4] = in_data.sample_4;
    assign in_w[5] = in_data.sample_5;
    assign in_w[6] = in_data.sample_6;
    assign in_w[7] = in_data.sample_7;

    // Phase step and wrap detection; the sum keeps the carry out of the phase width.
    logic [SUM_W-1:0] ph_sum;
    logic [3:0]       aset_inc;
    assign ph_sum   = SUM_W'(phase_reg) + SUM_W'(cfg.phase_step);
    assign aset_inc = {1'b0, aset_reg} + 4'd1;

    // Envelope table lookup.
    logic [TLOG-1:0]    idx;
    logic [PH_FRAC-1:0] fr;
    logic [TLOG:0]      idx_hi;
    assign idx    = snap_reg[PH_W-1:PH_FRAC];
    assign fr     = snap_reg[PH_FRAC-1:0];
    assign idx_hi = {1'b0, idx} + (TLOG+1)'(1);

    // Leading-one position of the envelope.
    logic [4:0] msb;
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < ENV_W; i++) begin
            if (env_reg[i]) msb = 5'(i);
        end
    end

    // Shared arithmetic terms.
    logic [32:0] sq;
    logic [24:0] nl;
    logic [41:0] ny;
    logic [60:0] mp;
    logic [9:0]  yi;
    logic [45:0] rnd;
    logic [17:0] coef0, coef1;
    logic [2:0]  ch;
    logic [SAMPLE_BITS:0] mag;
    logic [50:0] prod;
    logic [SAMPLE_BITS:0] rmag;
    logic [7:0]  mask;

    assign sq    = 33'((64'(x_reg) * 64'(x_reg)) >> 30);
    assign nl    = (25'(5'd16 - p_reg) << LOG_FRAC) - 25'(frac_reg);
    assign ny    = 42'(nl) * 42'(d_sat);
    assign mp    = 61'(m_reg) * 61'(root_w[5'(cmd.step + 5'd1)]);
    assign yi    = y_reg[29:20];
    assign rnd   = 46'(m_reg) + (46'd1 << (6'd13 + 6'(yi)));
    assign coef0 = {1'b0, base_reg, 4'b0};
    assign coef1 = coef0 + 18'(val_reg);
    assign ch    = cmd.step[2:0];
    assign mask  = cfg.set_masks[{aset_reg, 3'b0} +: 8];
    assign mag   = samp_reg[ch][SAMPLE_BITS-1]
                 ? (SAMPLE_BITS+1)'(-(SAMPLE_BITS+1)'(samp_reg[ch]))
                 : (SAMPLE_BITS+1)'(samp_reg[ch]);
    assign prod  = 51'(mag) * 51'(mask[ch] ? gc1_reg : gc0_reg);
    assign rmag  = (SAMPLE_BITS+1)'(prod >> 31);

    // Operation registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                snap_reg <= phase_reg;
                for (int c = 0; c < CHANNELS; c++) samp_reg[c] <= in_w[c];
            end
            OP_ROM:
            begin
                lo_reg <= rom_w[idx];
                hi_reg <= rom_w[idx_hi];
            end
            OP_ENV_A:
                acc_reg <= 41'(lo_reg) * 41'((23'd1 << PH_FRAC) - 23'(fr));
            OP_ENV_B:
                env_reg <= ENV_W'((acc_reg + 41'(hi_reg) * 41'(fr)
                                   + (41'd1 << (PH_FRAC - 1))) >> PH_FRAC);
            OP_LIN:
            begin
                val_reg  <= ENV_W'((34'(env_reg) * 34'(d_sat) + 34'd2048) >> 12);
                base_reg <= 13'(17'd4096 - d_sat);
            end
            OP_NORM:
            begin
                base_reg <= '0;
                val_reg  <= '0;
                p_reg    <= msb;
                x_reg    <= 31'(env_reg) << (5'd30 - msb);
                frac_reg <= '0;
            end
            OP_SQR:
            begin
                frac_reg <= {frac_reg[18:0], sq[31]};
                x_reg    <= sq[31] ? 31'(sq >> 1) : 31'(sq);
            end
            OP_YMUL:
            begin
                y_reg <= 30'(ny >> 12);
                m_reg <= 31'd1 << 30;
            end
            OP_POW:
            begin
                if (y_reg[5'd19 - cmd.step]) m_reg <= 31'(mp >> 30);
            end
            OP_VAL:
            begin
                if (env_reg != '0 && yi <= 10'd30)
                    val_reg <= ENV_W'(rnd >> (6'd14 + 6'(yi)));
            end
            OP_GC0:
                gc0_reg <= 34'(g_sat) * 34'(coef0);
            OP_GC1:
                gc1_reg <= 34'(g_sat) * 34'(coef1);
            OP_CHAN:
                res_reg[ch] <= samp_reg[ch][SAMPLE_BITS-1]
                             ? SAMPLE_BITS'(-rmag) : SAMPLE_BITS'(rmag);
            default:
            begin
            end
        endcase
    end

    // Phase, set rotation and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= '0;
            wrap_reg      <= 1'b0;
            aset_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_LOAD) begin
                if (wrap_reg) aset_reg <= (aset_inc >= cnt) ? 3'd0 : aset_inc[2:0];
                wrap_reg  <= (ph_sum >> PH_W) != '0;
                phase_reg <= ph_sum[PH_W-1:0];
            end
            if (cmd.op == OP_WRITE) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE) begin
            out_reg.out_0 <= res_reg[0];
            out_reg.out_1 <= res_reg[1];
            out_reg.out_2 <= res_reg[2];
            out_reg.out_3 <= res_reg[3];
            out_reg.out_4 <= res_reg[4];
            out_reg.out_5 <= res_reg[5];
            out_reg.out_6 <= res_reg[6];
            out_reg.out_7 <= res_reg[7];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
